>>> design/rrq_pkg.sv
// Shared types and codes for the round-robin ready queue.
// No dependencies; used by rrq_cell and round_robin_ready_queue.
package rrq_pkg;

	localparam int TASK_ID_W = 6;
	localparam int COUNT_W   = 7;

	// action codes
	localparam logic [1:0] ACT_ADD    = 2'd0;
	localparam logic [1:0] ACT_PICK   = 2'd1;
	localparam logic [1:0] ACT_REMOVE = 2'd2;

	// status codes
	localparam logic [1:0] ST_OK     = 2'd0;
	localparam logic [1:0] ST_IDLE   = 2'd1;
	localparam logic [1:0] ST_ABSENT = 2'd2;
	localparam logic [1:0] ST_DUP    = 2'd3;

	typedef struct packed {
		logic [1:0]           action;
		logic [TASK_ID_W-1:0] task_id;
	} in_beat_t;

	typedef struct packed {
		logic [1:0]           status;
		logic [TASK_ID_W-1:0] picked_id;
		logic                 picked_valid;
		logic [COUNT_W-1:0]   queued_count;
	} out_beat_t;

	// broadcast to every slot of the chain, at most one bit set
	typedef struct packed {
		logic add;     // load new id into the slot at the tail position
		logic rotate;  // shift left, head wraps into the last occupied slot
		logic drop;    // shift left, head falls off
	} chain_ctrl_t;

endpackage

>>> design/rrq_cell.sv
// One slot of the queue chain: holds the id at its position.
// Depends on rrq_pkg (chain_ctrl_t).
module rrq_cell #(
	parameter int ID_BITS = 6,
	parameter int IDX     = 0
) (
	input  logic                    clk,
	input  rrq_pkg::chain_ctrl_t    ctrl,
	input  logic [ID_BITS-1:0]      new_id,
	input  logic [ID_BITS-1:0]      right_id,
	input  logic [ID_BITS-1:0]      head_id,
	input  logic [ID_BITS:0]        count,
	input  logic [ID_BITS:0]        last_pos,
	output logic [ID_BITS-1:0]      id
);

	localparam logic [ID_BITS:0] MY_POS = (ID_BITS+1)'(IDX);

	logic [ID_BITS-1:0] id_q;

	// load at tail, take neighbor on shift, take head when this is the last slot
	always_ff @(posedge clk) begin
		priority if (ctrl.add && (count == MY_POS)) begin
			id_q <= new_id;
		end else if (ctrl.rotate) begin
			id_q <= (last_pos == MY_POS) ? head_id : right_id;
		end else if (ctrl.drop) begin
			id_q <= right_id;
		end
	end

	assign id = id_q;

endmodule

>>> design/round_robin_ready_queue.sv
// Top level of the round-robin ready queue: slot chain plus control.
// Depends on rrq_pkg and rrq_cell.
//
//  channel | handshake           | payload
//  --------+---------------------+-------------------------------
//  in      | in_valid / in_ready | in_data  (rrq_pkg::in_beat_t)
//  out     | out_valid/out_ready | out_data (rrq_pkg::out_beat_t)
//
// Add, pick, unused codes and remove of an absent id: result registered at the
// edge that takes the beat. Remove of a queued id: the beat is taken, then the
// chain is walked with one step per queued entry; each walk step moves the head
// slot once. One item in work at a time; a waiting result holds
// off the next beat only if it is not taken in that same cycle.
// Reset empties the queue at once; slot contents are don't care until written.
module round_robin_ready_queue #(
	parameter int ID_BITS = 6
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  rrq_pkg::in_beat_t  in_data,
	output logic               out_valid,
	input  logic               out_ready,
	output rrq_pkg::out_beat_t out_data
);

	localparam int ID_COUNT = 1 << ID_BITS;
	localparam int CW       = ID_BITS + 1;

	logic [ID_BITS-1:0]  slot_id [ID_COUNT];
	logic [ID_COUNT-1:0] queued_q, queued_d;
	logic [CW-1:0]       count_q, count_d;
	logic [CW-1:0]       steps_q, steps_d;
	logic [ID_BITS-1:0]  target_q;
	logic                walk_q, walk_d;
	logic                out_valid_q;
	rrq_pkg::out_beat_t  out_q, res;
	logic                res_load;
	rrq_pkg::chain_ctrl_t ctrl;
	logic                in_fire;
	logic [ID_BITS-1:0]  in_id;
	logic [ID_BITS-1:0]  head;
	logic [CW-1:0]       last_pos;

	assign in_ready = !walk_q && (!out_valid_q || out_ready);
	assign in_fire  = in_valid && in_ready;
	assign in_id    = ID_BITS'(in_data.task_id);
	assign head     = slot_id[0];
	assign last_pos = count_q - CW'(1);

	// chain of slots, slot 0 is the head
	for (genvar i = 0; i < ID_COUNT; i++) begin : g_slot
		logic [ID_BITS-1:0] right;
		if (i == ID_COUNT - 1) begin : g_end
			assign right = slot_id[i];
		end else begin : g_mid
			assign right = slot_id[i+1];
		end
		rrq_cell #(
			.ID_BITS (ID_BITS),
			.IDX     (i)
		) u_cell (
			.clk      (clk),
			.ctrl     (ctrl),
			.new_id   (in_id),
			.right_id (right),
			.head_id  (head),
			.count    (count_q),
			.last_pos (last_pos),
			.id       (slot_id[i])
		);
	end

	// decode the beat or advance the remove walk
	always_comb begin
		ctrl         = '0;
		count_d      = count_q;
		queued_d     = queued_q;
		steps_d      = steps_q;
		walk_d       = walk_q;
		res_load     = 1'b0;
		res          = '0;
		res.status   = rrq_pkg::ST_OK;
		if (in_fire) begin
			unique case (in_data.action)
				rrq_pkg::ACT_ADD: begin
					res_load = 1'b1;
					if (queued_q[in_id]) begin
						res.status = rrq_pkg::ST_DUP;
					end else begin
						ctrl.add        = 1'b1;
						count_d         = count_q + CW'(1);
						queued_d[in_id] = 1'b1;
					end
				end
				rrq_pkg::ACT_PICK: begin
					res_load = 1'b1;
					if (count_q == '0) begin
						res.status = rrq_pkg::ST_IDLE;
					end else begin
						ctrl.rotate      = 1'b1;
						res.picked_id    = rrq_pkg::TASK_ID_W'(head);
						res.picked_valid = 1'b1;
					end
				end
				rrq_pkg::ACT_REMOVE: begin
					if (!queued_q[in_id]) begin
						res_load   = 1'b1;
						res.status = rrq_pkg::ST_ABSENT;
					end else begin
						queued_d[in_id] = 1'b0;
						walk_d          = 1'b1;
						steps_d         = count_q;
					end
				end
				default: begin
					res_load = 1'b1;
				end
			endcase
		end else if (walk_q) begin
			// drop the target when it reaches the head, rotate everything else
			if (head == target_q) begin
				ctrl.drop = 1'b1;
				count_d   = count_q - CW'(1);
			end else begin
				ctrl.rotate = 1'b1;
			end
			steps_d = steps_q - CW'(1);
			if (steps_q == CW'(1)) begin
				walk_d   = 1'b0;
				res_load = 1'b1;
			end
		end
		res.queued_count = rrq_pkg::COUNT_W'(count_d);
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			queued_q    <= '0;
			count_q     <= '0;
			steps_q     <= '0;
			walk_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			queued_q <= queued_d;
			count_q  <= count_d;
			steps_q  <= steps_d;
			walk_q   <= walk_d;
			if (res_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// hold the remove target and the result beat
	always_ff @(posedge clk) begin
		if (in_fire) begin
			target_q <= in_id;
		end
		if (res_load) begin
			out_q <= res;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule
